[src/ac2c_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the second-chance cache.
// No dependencies.
package ac2c_pkg;

    localparam int DEF_LINES           = 64;
    localparam int DEF_STORE_WORD_BITS = 14;
    localparam int WORDS_PER_LINE      = 16;
    localparam int WORD_BITS           = 4;
    localparam int TAG_BITS            = 10;
    localparam int SA_BITS             = TAG_BITS + WORD_BITS;
    localparam int META_W              = TAG_BITS + 2;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_PRELOAD = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    // sa holds {tag, word}, the store word address of the item
    typedef struct packed {
        t_mode               mode;
        logic [SA_BITS-1:0]  sa;
        logic signed [31:0]  data;
    } t_req;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

[src/ac2c_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the second-chance cache: request and result.
// No dependencies.
interface ac2c_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [15:0]        byte_address;
    logic signed [31:0] write_data;
    modport source (output valid, mode, byte_address, write_data, input ready);
    modport sink   (input valid, mode, byte_address, write_data, output ready);
endinterface

interface ac2c_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_data;
    logic               hit;
    logic               wrote_back;
    modport source (output valid, read_data, hit, wrote_back, input ready);
    modport sink   (input valid, read_data, hit, wrote_back, output ready);
endinterface

[src/assoc_cache_second_chance.sv]
`timescale 1ns / 1ps
// Fully associative write-back cache with second-chance replacement, top level.
// Depends on ac2c_pkg, ac2c_if, ac2c_front and ac2c_back.
//
// Usage: request items enter on i_in (mode, byte_address, write_data) and each
// gives one result item on o_out (read_data, hit, wrote_back), in order.
// A two-entry queue takes requests while the back end works or a result waits.
// Steps per item: mode 2 or 3 is handled in the idle state. A read or write
// is issued, then searches the tag memory one line a cycle, then finishes on a
// hit. A miss first moves the hand past referenced lines, clearing their
// reference bits, writes the victim back if it is dirty, and refills the line.
// The tag and line memories each have a single read port.
// Reset: after i_rst_n the backing store is cleared one word a cycle,
// with i_in.ready low throughout; lines start invalid.
// A stalled o_out holds its result; the queue then fills and i_in.ready drops.
module assoc_cache_second_chance #(
    parameter int LINES           = ac2c_pkg::DEF_LINES,
    parameter int STORE_WORD_BITS = ac2c_pkg::DEF_STORE_WORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ac2c_in_if.sink    i_in,
    ac2c_out_if.source o_out
);
    import ac2c_pkg::*;

    logic       q_valid;
    t_req       q_req;
    logic       pop;
    t_back_stat stat;

    ac2c_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_stat(stat),
        .i_pop(pop), .o_q_valid(q_valid), .o_q_req(q_req)
    );

    ac2c_back #(.LINES(LINES), .STORE_WORD_BITS(STORE_WORD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_req(q_req),
        .o_pop(pop), .o_stat(stat), .o_out(o_out)
    );
endmodule

[src/ac2c_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ac2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[src/ac2c_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request items, decodes them and queues them for the back end.
// Depends on ac2c_pkg and ac2c_in_if.
module ac2c_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ac2c_in_if.sink             i_in,
    input  ac2c_pkg::t_back_stat i_stat,
    input  logic                i_pop,
    output logic                o_q_valid,
    output ac2c_pkg::t_req      o_q_req
);
    import ac2c_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_req       req_in;

    assign i_in.ready = (r_cnt != 2'd2) && !i_stat.clearing;
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_req    = r_q[r_rp];

    always_comb begin
        req_in.mode = t_mode'(i_in.mode);
        req_in.sa   = i_in.byte_address[15:2];
        req_in.data = i_in.write_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= req_in;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

[src/ac2c_back.sv]
`timescale 1ns / 1ps
// Back end: tag search, clock replacement, write-back, refill and result register.
// Depends on ac2c_pkg, ac2c_out_if and ac2c_ram.
module ac2c_back #(
    parameter int LINES           = ac2c_pkg::DEF_LINES,
    parameter int STORE_WORD_BITS = ac2c_pkg::DEF_STORE_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  ac2c_pkg::t_req       i_q_req,
    output logic                 o_pop,
    output ac2c_pkg::t_back_stat o_stat,
    ac2c_out_if.source           o_out
);
    import ac2c_pkg::*;

    localparam int LINE_W = $clog2(LINES);
    localparam int FILL_W = $clog2(LINES + 1);
    localparam int LW_W   = LINE_W + WORD_BITS;
    localparam int WCNT_W = WORD_BITS + 1;
    localparam int SWB    = STORE_WORD_BITS;

    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOOK   = 9'b000000100,
        S_SW_RD  = 9'b000001000,
        S_SW_CHK = 9'b000010000,
        S_WB     = 9'b000100000,
        S_FILL   = 9'b001000000,
        S_ACT    = 9'b010000000,
        S_RD     = 9'b100000000
    } t_state;

    function automatic logic [SWB-1:0] f_sidx(input logic [SA_BITS-1:0] idx);
        logic [SA_BITS+SWB-1:0] wide;
        wide = {{SWB{1'b0}}, idx};
        return wide[SWB-1:0];
    endfunction

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [FILL_W-1:0]     r_cnt, n_cnt;
    logic                  r_chk_v, n_chk_v;
    logic [LINE_W-1:0]     r_chk_idx, n_chk_idx;
    logic [LINE_W-1:0]     r_line, n_line;
    logic                  r_hit, n_hit;
    logic                  r_wb, n_wb;
    logic                  r_odirty, n_odirty;
    logic [LINE_W-1:0]     r_hand, n_hand;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [WCNT_W-1:0]     r_wcnt, n_wcnt;
    logic                  r_wv, n_wv;
    logic [TAG_BITS-1:0]   r_vtag, n_vtag;
    logic [SWB-1:0]        r_clr, n_clr;
    logic                  r_out_valid, n_out_valid;
    logic signed [31:0]    r_out_data, n_out_data;
    logic                  r_out_hit, n_out_hit;
    logic                  r_out_wb, n_out_wb;

    logic                  meta_we, meta_re;
    logic [LINE_W-1:0]     meta_waddr, meta_raddr;
    logic [META_W-1:0]     meta_wdata, meta_rd;
    logic                  word_we, word_re;
    logic [LW_W-1:0]       word_waddr, word_raddr;
    logic [31:0]           word_wdata, word_rd;
    logic                  st_we, st_re;
    logic [SWB-1:0]        st_waddr, st_raddr;
    logic [31:0]           st_wdata, st_rd;

    logic [TAG_BITS-1:0]   req_tag;
    logic [WORD_BITS-1:0]  req_word;
    logic [LINE_W-1:0]     hand_nxt;
    logic                  hand_valid;
    logic [WORD_BITS-1:0]  wpend;
    logic                  is_wr;

    assign req_tag  = r_req.sa[SA_BITS-1:WORD_BITS];
    assign req_word = r_req.sa[WORD_BITS-1:0];
    assign hand_nxt = (r_hand == LINE_W'(LINES - 1)) ? '0 : r_hand + 1'b1;
    assign hand_valid = (FILL_W'(r_hand) < r_fill);
    assign wpend    = WORD_BITS'(r_wcnt - WCNT_W'(1));
    assign is_wr    = (r_req.mode == MODE_WRITE);

    ac2c_ram #(.WIDTH(META_W), .DEPTH(LINES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_re(meta_re), .i_raddr(meta_raddr), .o_rdata(meta_rd)
    );
    ac2c_ram #(.WIDTH(32), .DEPTH(LINES * WORDS_PER_LINE)) u_words (
        .i_clk(i_clk), .i_we(word_we), .i_waddr(word_waddr), .i_wdata(word_wdata),
        .i_re(word_re), .i_raddr(word_raddr), .o_rdata(word_rd)
    );
    ac2c_ram #(.WIDTH(32), .DEPTH(1 << SWB)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rd)
    );

    assign o_stat.clearing = (r_state == S_CLR);
    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out_data;
    assign o_out.hit        = r_out_hit;
    assign o_out.wrote_back = r_out_wb;

    always_comb begin
        n_state = r_state;  n_req = r_req;  n_cnt = r_cnt;  n_chk_v = r_chk_v;
        n_chk_idx = r_chk_idx;  n_line = r_line;  n_hit = r_hit;  n_wb = r_wb;
        n_odirty = r_odirty;  n_hand = r_hand;  n_fill = r_fill;  n_wcnt = r_wcnt;
        n_wv = r_wv;  n_vtag = r_vtag;  n_clr = r_clr;
        n_out_valid = r_out_valid;  n_out_data = r_out_data;
        n_out_hit = r_out_hit;  n_out_wb = r_out_wb;
        o_pop = 1'b0;
        meta_we = 1'b0;  meta_waddr = r_line;  meta_wdata = '0;
        meta_re = 1'b0;  meta_raddr = r_hand;
        word_we = 1'b0;  word_waddr = {r_line, req_word};  word_wdata = r_req.data;
        word_re = 1'b0;  word_raddr = {r_line, req_word};
        st_we = 1'b0;  st_waddr = r_clr;  st_wdata = '0;
        st_re = 1'b0;  st_raddr = f_sidx({req_tag, r_wcnt[WORD_BITS-1:0]});

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                st_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // take the next item as soon as the result register drains
                if (i_q_valid && (!r_out_valid || o_out.ready)) begin
                    o_pop = 1'b1;
                    n_req = i_q_req;
                    case (i_q_req.mode)
                        MODE_READ, MODE_WRITE: begin
                            n_cnt   = '0;
                            n_chk_v = 1'b0;
                            n_state = S_LOOK;
                        end
                        MODE_PRELOAD: begin
                            st_we       = 1'b1;
                            st_waddr    = f_sidx(i_q_req.sa);
                            st_wdata    = i_q_req.data;
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_hit   = 1'b0;
                            n_out_wb    = 1'b0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_hit   = 1'b0;
                            n_out_wb    = 1'b0;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                // search one line a cycle; data of the previous read checked here
                if (r_chk_v && meta_rd[META_W-1:2] == req_tag) begin
                    n_line   = r_chk_idx;
                    n_hit    = 1'b1;
                    n_wb     = 1'b0;
                    n_odirty = meta_rd[0];
                    n_state  = S_ACT;
                end else if (r_cnt < r_fill) begin
                    meta_re    = 1'b1;
                    meta_raddr = r_cnt[LINE_W-1:0];
                    n_chk_idx  = r_cnt[LINE_W-1:0];
                    n_chk_v    = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                end else begin
                    n_hit   = 1'b0;
                    n_chk_v = 1'b0;
                    n_state = S_SW_RD;
                end
            end
            S_SW_RD: begin
                meta_re = 1'b1;
                n_state = S_SW_CHK;
            end
            S_SW_CHK: begin
                // lines past the fill count are invalid and read as unreferenced
                if (hand_valid && meta_rd[1]) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_hand;
                    meta_wdata = {meta_rd[META_W-1:2], 1'b0, meta_rd[0]};
                    n_hand     = hand_nxt;
                    n_state    = S_SW_RD;
                end else begin
                    n_line   = r_hand;
                    n_hand   = hand_nxt;
                    n_vtag   = meta_rd[META_W-1:2];
                    n_wcnt   = '0;
                    n_wv     = 1'b0;
                    n_odirty = 1'b0;
                    n_wb     = hand_valid && meta_rd[0];
                    if (!hand_valid) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = (hand_valid && meta_rd[0]) ? S_WB : S_FILL;
                end
            end
            S_WB: begin
                if (r_wv) begin
                    st_we    = 1'b1;
                    st_waddr = f_sidx({r_vtag, wpend});
                    st_wdata = word_rd;
                end
                if (r_wcnt < WCNT_W'(WORDS_PER_LINE)) begin
                    word_re    = 1'b1;
                    word_raddr = {r_line, r_wcnt[WORD_BITS-1:0]};
                    n_wcnt     = r_wcnt + 1'b1;
                    n_wv       = 1'b1;
                end else begin
                    n_wcnt  = '0;
                    n_wv    = 1'b0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_wv) begin
                    word_we    = 1'b1;
                    word_waddr = {r_line, wpend};
                    word_wdata = st_rd;
                end
                if (r_wcnt < WCNT_W'(WORDS_PER_LINE)) begin
                    st_re  = 1'b1;
                    n_wcnt = r_wcnt + 1'b1;
                    n_wv   = 1'b1;
                end else begin
                    n_wv    = 1'b0;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                meta_we    = 1'b1;
                meta_waddr = r_line;
                meta_wdata = {req_tag, r_hit | is_wr, is_wr | (r_hit & r_odirty)};
                if (is_wr) begin
                    word_we     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_hit   = r_hit;
                    n_out_wb    = r_wb;
                    n_state     = S_IDLE;
                end else begin
                    word_re = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_out_valid = 1'b1;
                n_out_data  = word_rd;
                n_out_hit   = r_hit;
                n_out_wb    = r_wb;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_hand      <= '0;
            r_fill      <= '0;
            r_chk_v     <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hand      <= n_hand;
            r_fill      <= n_fill;
            r_chk_v     <= n_chk_v;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cnt      <= n_cnt;
        r_chk_idx  <= n_chk_idx;
        r_line     <= n_line;
        r_hit      <= n_hit;
        r_wb       <= n_wb;
        r_odirty   <= n_odirty;
        r_wcnt     <= n_wcnt;
        r_vtag     <= n_vtag;
        r_out_data <= n_out_data;
        r_out_hit  <= n_out_hit;
        r_out_wb   <= n_out_wb;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LINES))
        else $error("fill count beyond line count");
    a_hand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_hand} < (LINE_W + 1)'(LINES))
        else $error("clock hand out of range");
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !r_out_valid && !o_pop)
        else $error("item handled during store clearing");
    a_act_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT || r_state == S_RD) |-> !r_out_valid)
        else $error("result register busy while finishing an item");
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for assoc_cache_second_chance: random and directed
// reads, writes and preloads, checked against a behavioural cache model.
// Depends on ac2c_pkg, ac2c_if and the cache RTL.
module testbench;
    import ac2c_pkg::*;

    localparam int NLINES     = DEF_LINES;
    localparam int STORE_BITS = DEF_STORE_WORD_BITS;
    localparam int STORE_SIZE = 1 << STORE_BITS;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] addr;
        logic [31:0] data;
    } t_access;

    typedef struct packed {
        logic [31:0] rdata;
        logic        hit;
        logic        wb;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    ac2c_in_if  req_ch ();
    ac2c_out_if rsp_ch ();

    assoc_cache_second_chance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (rsp_ch.source)
    );

    // cache model state
    logic [9:0]  m_tag   [NLINES];
    logic        m_valid [NLINES];
    logic        m_ref   [NLINES];
    logic        m_dirty [NLINES];
    logic [31:0] m_words [NLINES*16];
    logic [31:0] m_store [STORE_SIZE];
    int          m_hand;

    t_access pending_q [$];
    t_answer expected_q [$];
    int      errors;
    longint  cycles;
    bit      hold_sender;
    int      send_gap;
    int      recv_gap;

    function automatic int store_idx(logic [9:0] tag, int w);
        return ((int'(tag) << 4) | w) & (STORE_SIZE - 1);
    endfunction

    function automatic t_answer cache_access(t_access a);
        t_answer r;
        logic [9:0] tag;
        int wd, n, v;
        r = '0;
        tag = a.addr[15:6];
        wd = a.addr[5:2];
        n = -1;
        if (a.mode == MODE_READ || a.mode == MODE_WRITE) begin
            for (int i = 0; i < NLINES; i++)
                if (n < 0 && m_valid[i] && m_tag[i] == tag) n = i;
            if (n >= 0) begin
                r.hit = 1'b1;
            end else begin
                while (m_ref[m_hand]) begin
                    m_ref[m_hand] = 1'b0;
                    m_hand = (m_hand + 1) % NLINES;
                end
                v = m_hand;
                m_hand = (v + 1) % NLINES;
                if (m_dirty[v]) begin
                    for (int w = 0; w < 16; w++)
                        m_store[store_idx(m_tag[v], w)] = m_words[v*16+w];
                    r.wb = 1'b1;
                end
                m_tag[v] = tag;
                m_valid[v] = 1'b1;
                m_ref[v] = 1'b0;
                m_dirty[v] = 1'b0;
                for (int w = 0; w < 16; w++)
                    m_words[v*16+w] = m_store[store_idx(tag, w)];
                n = v;
            end
            if (a.mode == MODE_READ) begin
                if (r.hit) m_ref[n] = 1'b1;
                r.rdata = m_words[n*16+wd];
            end else begin
                m_ref[n] = 1'b1;
                m_dirty[n] = 1'b1;
                m_words[n*16+wd] = a.data;
            end
        end else if (a.mode == MODE_PRELOAD) begin
            m_store[a.addr[15:2] & (STORE_SIZE - 1)] = a.data;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                expected_q.push_back(cache_access(
                    t_access'{t_mode'(req_ch.mode), req_ch.byte_address,
                              req_ch.write_data}));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_q.size() > 0 && !hold_sender) begin
                t_access a;
                a = pending_q.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.mode <= a.mode;
                req_ch.byte_address <= a.addr;
                req_ch.write_data <= a.data;
                send_gap <= pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result rd=%h hit=%b wb=%b", $time,
                             rsp_ch.read_data, rsp_ch.hit, rsp_ch.wrote_back);
                    errors++;
                end else begin
                    t_answer e;
                    e = expected_q.pop_front();
                    if (e.rdata !== rsp_ch.read_data) begin
                        $display("%0t: read_data expected %h actual %h", $time,
                                 e.rdata, rsp_ch.read_data);
                        errors++;
                    end
                    if (e.hit !== rsp_ch.hit) begin
                        $display("%0t: hit expected %b actual %b", $time,
                                 e.hit, rsp_ch.hit);
                        errors++;
                    end
                    if (e.wb !== rsp_ch.wrote_back) begin
                        $display("%0t: wrote_back expected %b actual %b", $time,
                                 e.wb, rsp_ch.wrote_back);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_access rnd_access(int tag_span);
        t_access a;
        int p;
        p = $urandom_range(99);
        a.mode = p < 45 ? MODE_READ : p < 85 ? MODE_WRITE : p < 97 ? MODE_PRELOAD
                 : MODE_NONE;
        // mostly a small tag pool so that hits, evictions and sweeps all occur
        a.addr = {10'($urandom_range(tag_span - 1)), 6'($urandom)};
        if ($urandom_range(9) == 0) a.addr = 16'($urandom);
        a.data = $urandom;
        return a;
    endfunction

    initial begin
        t_access a;
        errors = 0;
        cycles = 0;
        hold_sender = 1'b0;
        m_hand = 0;
        for (int i = 0; i < NLINES; i++) begin
            m_tag[i] = '0; m_valid[i] = 0; m_ref[i] = 0; m_dirty[i] = 0;
        end
        foreach (m_words[i]) m_words[i] = '0;
        foreach (m_store[i]) m_store[i] = '0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_READ;
        req_ch.byte_address = '0;
        req_ch.write_data = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, each mode, preload under a cached line, unused mode
        pending_q.push_back('{MODE_READ, 16'h0000, 32'h0});
        pending_q.push_back('{MODE_WRITE, 16'hFFFF, 32'hFFFF_FFFF});
        pending_q.push_back('{MODE_WRITE, 16'h0003, 32'h8000_0000});
        pending_q.push_back('{MODE_READ, 16'h0000, 32'h0});
        pending_q.push_back('{MODE_PRELOAD, 16'h0004, 32'h7FFF_FFFF});
        pending_q.push_back('{MODE_READ, 16'h0004, 32'h0});
        pending_q.push_back('{MODE_PRELOAD, 16'hFFFC, 32'h1234_5678});
        pending_q.push_back('{MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF});
        pending_q.push_back('{MODE_READ, 16'hFFFC, 32'h0});
        pending_q.push_back('{MODE_PRELOAD, 16'h0140, 32'hA5A5_5A5A});
        pending_q.push_back('{MODE_READ, 16'h0140, 32'h0});
        // fill every line and reference all of them, then force a full sweep
        for (int t = 0; t < NLINES + 2; t++)
            pending_q.push_back('{MODE_WRITE, 16'(t << 6), 32'($urandom)});
        for (int t = 0; t < 10; t++)
            pending_q.push_back('{MODE_READ, 16'((t + 100) << 6), 32'h0});

        wait (pending_q.size() == 0);
        hold_sender = 1'b1;
        wait (expected_q.size() == 0 && !req_ch.valid);
        hold_sender = 1'b0;

        for (int i = 0; i < 750; i++) begin
            a = rnd_access(i < 500 ? 96 : 1024);
            pending_q.push_back(a);
        end
        wait (pending_q.size() == 0);
        wait (expected_q.size() == 0 && !req_ch.valid);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
